// ===== rtl/core/eutot_pkg.sv =====
// Shared constants for the trial-division totient block.
package eutot_pkg;

   // Default width of value and totient words
   localparam int unsigned VALUE_WIDTH_DEFAULT = 32;

   // First trial divisor
   localparam int unsigned FIRST_DIVISOR = 2;

endpackage

// ===== rtl/core/eutot_if.sv =====
// Request channel: one value word per handshake.
interface eutot_req_if #(
   parameter int unsigned WIDTH = eutot_pkg::VALUE_WIDTH_DEFAULT
);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

// Response channel: totient and error flag per word.
interface eutot_rsp_if #(
   parameter int unsigned WIDTH = eutot_pkg::VALUE_WIDTH_DEFAULT
);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] totient;
   logic             bad_input;

   modport source (output valid, output totient, output bad_input, input ready);
   modport sink   (input valid, input totient, input bad_input, output ready);
endinterface

// ===== rtl/core/euler_totient_trial_division.sv =====
// Euler totient by trial division.
// req_ch (sink): one unsigned value word per handshake (valid && ready).
// rsp_ch (source): one word back per request, totient plus bad_input.
// A zero value returns totient 0 with bad_input set, offered the cycle after accept.
// The block takes one request at a time: req_ch.ready is high only while idle,
// so the next word is taken no earlier than the cycle after the response goes.
// Every trial divisor costs one restoring division plus one evaluate step;
// each prime factor found adds one more division and a shift-add multiply.
// Divisors are tried from 2 upward until one's square exceeds the unfactored
// part. Both the division and the multiply run on one shared add/subtract unit.
// The response word is held in output registers until rsp_ch.ready; a stalled
// receiver simply keeps the block in its done state, nothing is lost.
// Synchronous active-high reset returns the sequencer to idle; any word in
// flight is dropped and no response is shown.
module euler_totient_trial_division #(
   parameter int unsigned VALUE_WIDTH = eutot_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   eutot_req_if.sink    req_ch,
   eutot_rsp_if.source  rsp_ch
);

   localparam int unsigned W     = VALUE_WIDTH;
   localparam int unsigned CNT_W = $clog2(W);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_DIV  = 5'b00010,
      ST_EVAL = 5'b00100,
      ST_MUL  = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   state_type        state_ff,   state_in;
   logic [W-1:0]     rest_ff,    rest_in;     // unfactored part
   logic [W-1:0]     acc_ff,     acc_in;      // running totient
   logic [W-1:0]     div_ff,     div_in;      // trial divisor
   logic [W-1:0]     rem_ff,     rem_in;      // remainder / product
   logic [W-1:0]     quo_ff,     quo_in;      // quotient / multiplicand
   logic [W-1:0]     mlt_ff,     mlt_in;      // multiplier, shifts right
   logic [CNT_W-1:0] cnt_ff,     cnt_in;
   logic             extract_ff, extract_in;  // current divisor already hit
   logic             last_ff,    last_in;     // multiply is the final one
   logic [W-1:0]     tot_ff,     tot_in;
   logic             bad_ff,     bad_in;

   // Shared add/subtract unit
   logic [W:0]       op_a;
   logic [W-1:0]     op_b;
   logic             op_sub;
   logic [W+1:0]     sum;
   logic             sum_neg;
   logic             cnt_last;

   assign sum      = {1'b0, op_a} + (op_sub ? ~{2'b00, op_b} : {2'b00, op_b})
                     + {{(W+1){1'b0}}, op_sub};
   assign sum_neg  = sum[W+1];
   assign cnt_last = (cnt_ff == CNT_W'(W - 1));

   // Operand select for the shared unit
   always_comb begin
      if (state_ff == ST_MUL) begin
         op_a   = {1'b0, rem_ff};
         op_b   = quo_ff;
         op_sub = 1'b0;
      end else begin
         op_a   = {rem_ff, quo_ff[W-1]};
         op_b   = div_ff;
         op_sub = 1'b1;
      end
   end

   // Sequencer
   always_comb begin
      logic [W-1:0] prod;
      state_in   = state_ff;
      rest_in    = rest_ff;
      acc_in     = acc_ff;
      div_in     = div_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      mlt_in     = mlt_ff;
      cnt_in     = cnt_ff;
      extract_in = extract_ff;
      last_in    = last_ff;
      tot_in     = tot_ff;
      bad_in     = bad_ff;
      prod       = mlt_ff[0] ? sum[W-1:0] : rem_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               if (req_ch.value == '0) begin
                  tot_in   = '0;
                  bad_in   = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  bad_in     = 1'b0;
                  rest_in    = req_ch.value;
                  acc_in     = W'(1);
                  div_in     = W'(eutot_pkg::FIRST_DIVISOR);
                  extract_in = 1'b0;
                  rem_in     = '0;
                  quo_in     = req_ch.value;
                  cnt_in     = '0;
                  state_in   = ST_DIV;
               end
            end
         end

         // Restoring division rest / div, one quotient bit per cycle
         ST_DIV: begin
            rem_in = sum_neg ? op_a[W-1:0] : sum[W-1:0];
            quo_in = {quo_ff[W-2:0], ~sum_neg};
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_last) begin
               state_in = ST_EVAL;
            end
         end

         // Decide on quotient quo_ff and remainder rem_ff
         ST_EVAL: begin
            rem_in = '0;
            cnt_in = '0;
            priority if (extract_ff && rem_ff == '0) begin
               // another factor of the same prime: acc *= div
               rest_in  = quo_ff;
               quo_in   = acc_ff;
               mlt_in   = div_ff;
               last_in  = 1'b0;
               state_in = ST_MUL;
            end else if (extract_ff) begin
               extract_in = 1'b0;
               div_in     = div_ff + W'(1);
               quo_in     = rest_ff;
               state_in   = ST_DIV;
            end else if (div_ff > quo_ff) begin
               // divisor squared exceeds rest: leftover is prime or one
               if (rest_ff > W'(1)) begin
                  quo_in   = acc_ff;
                  mlt_in   = rest_ff - W'(1);
                  last_in  = 1'b1;
                  state_in = ST_MUL;
               end else begin
                  tot_in   = acc_ff;
                  state_in = ST_DONE;
               end
            end else if (rem_ff != '0) begin
               div_in   = div_ff + W'(1);
               quo_in   = rest_ff;
               state_in = ST_DIV;
            end else begin
               // first factor of a new prime: acc *= div - 1
               rest_in    = quo_ff;
               extract_in = 1'b1;
               quo_in     = acc_ff;
               mlt_in     = div_ff - W'(1);
               last_in    = 1'b0;
               state_in   = ST_MUL;
            end
         end

         // Shift-add multiply acc * mlt, modulo 2^W
         ST_MUL: begin
            rem_in = prod;
            quo_in = {quo_ff[W-2:0], 1'b0};
            mlt_in = {1'b0, mlt_ff[W-1:1]};
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_last) begin
               acc_in = prod;
               if (last_ff) begin
                  tot_in   = prod;
                  state_in = ST_DONE;
               end else begin
                  rem_in   = '0;
                  quo_in   = rest_ff;
                  cnt_in   = '0;
                  state_in = ST_DIV;
               end
            end
         end

         ST_DONE: begin
            if (rsp_ch.ready) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      rest_ff    <= rest_in;
      acc_ff     <= acc_in;
      div_ff     <= div_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      mlt_ff     <= mlt_in;
      cnt_ff     <= cnt_in;
      extract_ff <= extract_in;
      last_ff    <= last_in;
      tot_ff     <= tot_in;
      bad_ff     <= bad_in;
   end

   // Channel outputs
   assign req_ch.ready     = (state_ff == ST_IDLE);
   assign rsp_ch.valid     = (state_ff == ST_DONE);
   assign rsp_ch.totient   = tot_ff;
   assign rsp_ch.bad_input = bad_ff;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;

   localparam int unsigned VW           = eutot_pkg::VALUE_WIDTH_DEFAULT;
   localparam int unsigned RANDOM_ITEMS = 80;
   localparam int unsigned QUIET_ITEMS  = 20;
   localparam int unsigned LONG_HOLD    = 6000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // idle bursts on both sides until the quiet tail of the run
   bit idle_on         = 1'b1;
   bit long_hold_asked = 1'b0;

   eutot_req_if #(.WIDTH(VW)) req_ch ();
   eutot_rsp_if #(.WIDTH(VW)) rsp_ch ();

   euler_totient_trial_division #(.VALUE_WIDTH(VW)) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Expected totient words, oldest first, plus the predictor that fills them.
   class totient_book;
      typedef struct {
         logic [VW-1:0] value;
         logic [VW-1:0] totient;
         logic          bad_input;
      } totient_word_type;

      totient_word_type awaited_totients[$];
      int unsigned      mismatches;

      function new();
         mismatches = 0;
      endfunction

      // phi(v): strip each prime power found by trial division
      function logic [VW-1:0] totient_of_value(logic [VW-1:0] v);
         longint unsigned rest;
         longint unsigned acc;
         longint unsigned d;
         longint unsigned power;
         rest = 64'(v);
         acc  = 1;
         for (d = 64'(eutot_pkg::FIRST_DIVISOR); d <= rest / d; d++) begin
            if (rest % d == 0) begin
               power = 1;
               while (rest % d == 0) begin
                  rest  = rest / d;
                  power = power * d;
               end
               acc = acc * (power - power / d);
            end
         end
         // leftover above 1 is a prime
         if (rest > 1)
            acc = acc * (rest - 1);
         return acc[VW-1:0];
      endfunction

      function void note_value(logic [VW-1:0] v);
         totient_word_type w;
         w.value     = v;
         w.bad_input = (v == 0);
         w.totient   = (v == 0) ? '0 : totient_of_value(v);
         awaited_totients.push_back(w);
      endfunction

      function void check_word(logic [VW-1:0] totient, logic bad_input);
         totient_word_type w;
         if (awaited_totients.size() == 0) begin
            $display("%0t: unexpected word totient=%0d bad_input=%0b",
                     $time, totient, bad_input);
            mismatches++;
            return;
         end
         w = awaited_totients.pop_front();
         if (totient !== w.totient) begin
            $display("%0t: value %0d totient expected %0d actual %0d",
                     $time, w.value, w.totient, totient);
            mismatches++;
         end
         if (bad_input !== w.bad_input) begin
            $display("%0t: value %0d bad_input expected %0b actual %0b",
                     $time, w.value, w.bad_input, bad_input);
            mismatches++;
         end
      endfunction

      function int unsigned pending();
         return awaited_totients.size();
      endfunction
   endclass

   totient_book book;

   // zero, one, prime squares, a large prime, near-square semiprime, wide words
   logic [VW-1:0] edge_values[20] = '{
      32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd25, 32'd49, 32'd97, 32'd121,
      32'd60491, 32'd1048573, 32'd1048576, 32'd223092870, 32'd3486784401,
      32'h8000_0000, 32'hFFFF_0000, 32'hAAAA_AAAA, 32'h5555_5555,
      32'hFFFF_FFFF, 32'd0
   };

   int unsigned small_primes[11] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31};

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Random values: mostly small, some smooth wide ones, a few zeros.
   // Smooth products keep the division loop short yet reach the top bits.
   function automatic logic [VW-1:0] pick_value();
      longint unsigned m;
      longint unsigned p;
      longint unsigned top;
      int unsigned     kind;
      top  = (64'd1 << VW) - 1;
      kind = $urandom_range(0, 9);
      if (kind == 0)
         return VW'($urandom_range(0, 3));
      if (kind <= 5)
         return VW'($urandom_range(1, 4095));
      m = 64'($urandom_range(1, 255));
      while ($urandom_range(0, 15) != 0) begin
         p = 64'(small_primes[$urandom_range(0, 10)]);
         if (m * p > top)
            break;
         m = m * p;
      end
      return m[VW-1:0];
   endfunction

   // Offer one word, with an optional gap first; returns at the accepting edge.
   task automatic send_value(input logic [VW-1:0] v);
      int unsigned gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 18);
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.value <= v;
      do
         @(posedge clock);
      while (!req_ch.ready);
      book.note_value(v);
   endtask

   // Receiver: random ready pattern, one long hold-off on request.
   initial begin
      int unsigned span;
      rsp_ch.ready <= 1'b0;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         if (long_hold_asked) begin
            long_hold_asked = 1'b0;
            rsp_ch.ready <= 1'b0;
            span = LONG_HOLD;
         end else if (idle_on && $urandom_range(0, 2) == 0) begin
            rsp_ch.ready <= 1'b0;
            span = $urandom_range(1, 18);
         end else begin
            rsp_ch.ready <= 1'b1;
            span = $urandom_range(1, 30);
         end
         repeat (span) @(posedge clock);
      end
   end

   // Result check at every accepted word
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         book.check_word(rsp_ch.totient, rsp_ch.bad_input);
   end

   // Main sequence
   initial begin
      int unsigned i;
      book = new();
      req_ch.valid <= 1'b0;
      req_ch.value <= '0;
      reset        <= 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (edge_values[k])
         send_value(edge_values[k]);

      // receiver stalls while the sender keeps offering
      long_hold_asked = 1'b1;
      for (i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS - QUIET_ITEMS)
            idle_on = 1'b0;
         send_value(pick_value());
      end
      req_ch.valid <= 1'b0;

      while (book.pending() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);

      if (book.mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   // Watchdog
   initial begin
      #8000000;
      $display("FAIL");
      $finish;
   end

endmodule
